/* rtl/imhpq_pkg.sv */
`timescale 1ns / 1ps
package imhpq_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int NODE_IDS_DEF = 1024;

  localparam int OP_W     = 3;
  localparam int NODE_W   = 10;
  localparam int COST_W   = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 11;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 56;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_POP    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_CHANGE = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_PEEK   = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_LOOK,
    S_CHK,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [COST_W-1:0] key;
  } slot_t;

endpackage

/* rtl/indexed_min_heap_priority_queue_core.sv */
`timescale 1ns / 1ps
// Indexed binary min-heap of node ids keyed by unsigned Q16.16 cost. One item
// in, one result item out. The heap lives in a slot memory (two read ports, one
// write port) and each node's slot in a position memory; membership is
// checked by reading a node's slot and matching the node id stored there, so
// clear only resets the entry count. Peek, clear, pop of an empty or one-entry
// heap and unused codes touch no slot and answer from S_LOOK; items that change
// the heap sift level by level, each level a memory read, then a compare and
// write back. After reset the position memory is swept to zero, during which
// no item is accepted.
module indexed_min_heap_priority_queue_core #(
  parameter int CAPACITY = imhpq_pkg::CAPACITY_DEF,
  parameter int NODE_IDS = imhpq_pkg::NODE_IDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // operation[2:0], node_id[12:3], cost[44:13], zero pad
  input  logic [imhpq_pkg::IN_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // status[2:0], out_node[12:3], out_cost[44:13], count[55:45]
  output logic [imhpq_pkg::OUT_W-1:0] out_tdata
);
  import imhpq_pkg::*;

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = SW + 2;
  localparam int NW = (NODE_IDS > 1) ? $clog2(NODE_IDS) : 1;

  slot_t         heap_mem [CAPACITY];
  logic [SW-1:0] pos_mem  [NODE_IDS];

  state_t state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [NODE_W-1:0] id_r, id_nxt;
  logic [COST_W-1:0] key_r, key_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [SW-1:0]     pos_r, pos_nxt;
  slot_t             mov_r, mov_nxt;
  slot_t             last_r, last_nxt;
  logic [NW-1:0]     clr_r, clr_nxt;
  logic              ov_r, ov_nxt;
  logic [OUT_W-1:0]  od_r, od_nxt;

  logic [SW-1:0] ha_addr, hb_addr, hw_addr;
  logic          hw_en;
  slot_t         hw_data, ha_q, hb_q;
  logic [NW-1:0] pr_addr, pw_addr;
  logic          pw_en;
  logic [SW-1:0] pw_data, pr_q;

  always_ff @(posedge clk) begin
    if (hw_en) begin
      heap_mem[hw_addr] <= hw_data;
    end
    ha_q <= heap_mem[ha_addr];
    hb_q <= heap_mem[hb_addr];
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      pos_mem[pw_addr] <= pw_data;
    end
    pr_q <= pos_mem[pr_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    id_r   <= id_nxt;
    key_r  <= key_nxt;
    pos_r  <= pos_nxt;
    mov_r  <= mov_nxt;
    last_r <= last_nxt;
    od_r   <= od_nxt;
  end

  logic              id_ok, member, right_ok, take_right;
  logic [CW-1:0]     cnt_dec;
  logic [SW-1:0]     parent;
  logic [LW-1:0]     left, right;
  slot_t             pick;
  logic [SW-1:0]     pick_addr;

  assign in_tready  = (state_r == S_IDLE) && (!ov_r || out_tready);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  always_comb begin
    id_ok      = 32'(id_r) < NODE_IDS;
    member     = id_ok && (CW'(pos_r) < cnt_r) && (ha_q.node == id_r);
    cnt_dec    = cnt_r - CW'(1);
    parent     = (pos_r - SW'(1)) >> 1;
    left       = {1'b0, pos_r, 1'b0} + LW'(1);
    right      = left + LW'(1);
    right_ok   = right < LW'(cnt_r);
    take_right = right_ok && (ha_q.key >= hb_q.key);
    pick       = take_right ? hb_q : ha_q;
    pick_addr  = take_right ? right[SW-1:0] : left[SW-1:0];

    state_nxt = state_r;
    op_nxt    = op_r;
    id_nxt    = id_r;
    key_nxt   = key_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    mov_nxt   = mov_r;
    last_nxt  = last_r;
    clr_nxt   = clr_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;

    ha_addr = '0;
    hb_addr = '0;
    hw_en   = 1'b0;
    hw_addr = pos_r;
    hw_data = mov_r;
    pr_addr = NW'(id_r);
    pw_en   = 1'b0;
    pw_addr = NW'(mov_r.node);
    pw_data = pos_r;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        pw_en   = 1'b1;
        pw_addr = clr_r;
        pw_data = '0;
        clr_nxt = clr_r + NW'(1);
        if (32'(clr_r) == NODE_IDS - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        pr_addr = NW'(in_tdata[12:3]);
        ha_addr = '0;
        hb_addr = SW'(cnt_dec);
        if (in_tvalid && in_tready) begin
          op_nxt    = in_tdata[2:0];
          id_nxt    = in_tdata[12:3];
          key_nxt   = in_tdata[44:13];
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        last_nxt = hb_q;
        pos_nxt  = pr_q;
        ha_addr  = pr_q;
        case (op_r)
          OP_INSERT, OP_REMOVE, OP_CHANGE: begin
            state_nxt = S_CHK;
          end
          OP_POP, OP_PEEK: begin
            if (cnt_r == '0) begin
              od_nxt    = {COUNT_W'(cnt_r), COST_W'(0), NODE_W'(0), ST_EMPTY};
              ov_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end else if (op_r == OP_PEEK || cnt_dec == '0) begin
              if (op_r == OP_POP) begin
                cnt_nxt = cnt_dec;
              end
              od_nxt    = {COUNT_W'(op_r == OP_POP ? cnt_dec : cnt_r), ha_q.key,
                           ha_q.node, ST_OK};
              ov_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              cnt_nxt   = cnt_dec;
              od_nxt    = {COUNT_W'(cnt_dec), ha_q.key, ha_q.node, ST_OK};
              mov_nxt   = hb_q;
              pos_nxt   = '0;
              state_nxt = S_DN_RD;
            end
          end
          OP_CLEAR: begin
            cnt_nxt   = '0;
            od_nxt    = {COUNT_W'(0), COST_W'(0), NODE_W'(0), ST_OK};
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
          default: begin
            od_nxt    = {COUNT_W'(cnt_r), COST_W'(0), NODE_W'(0), ST_OK};
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_CHK: begin
        od_nxt    = {COUNT_W'(cnt_r), COST_W'(0), NODE_W'(0), ST_OK};
        state_nxt = S_IDLE;
        if (op_r == OP_INSERT) begin
          if (!id_ok) begin
            od_nxt[STATUS_W-1:0] = ST_ABSENT;
            ov_nxt = 1'b1;
          end else if (member) begin
            od_nxt[STATUS_W-1:0] = ST_PRESENT;
            ov_nxt = 1'b1;
          end else if (32'(cnt_r) >= CAPACITY) begin
            od_nxt[STATUS_W-1:0] = ST_FULL;
            ov_nxt = 1'b1;
          end else begin
            cnt_nxt   = cnt_r + CW'(1);
            od_nxt    = {COUNT_W'(cnt_r + CW'(1)), COST_W'(0), NODE_W'(0), ST_OK};
            pos_nxt   = SW'(cnt_r);
            mov_nxt   = '{node: id_r, key: key_r};
            state_nxt = S_UP_RD;
          end
        end else if (!member) begin
          od_nxt[STATUS_W-1:0] = ST_ABSENT;
          ov_nxt = 1'b1;
        end else if (op_r == OP_REMOVE) begin
          cnt_nxt = cnt_dec;
          od_nxt  = {COUNT_W'(cnt_dec), COST_W'(0), NODE_W'(0), ST_OK};
          if (CW'(pos_r) < cnt_dec) begin
            mov_nxt   = last_r;
            state_nxt = (last_r.key >= ha_q.key) ? S_DN_RD : S_UP_RD;
          end else begin
            ov_nxt = 1'b1;
          end
        end else begin
          mov_nxt   = '{node: id_r, key: key_r};
          state_nxt = (key_r >= ha_q.key) ? S_DN_RD : S_UP_RD;
        end
      end
      S_UP_RD: begin
        ha_addr = parent;
        if (pos_r == '0) begin
          hw_en     = 1'b1;
          pw_en     = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        hw_en = 1'b1;
        pw_en = 1'b1;
        if (mov_r.key >= ha_q.key) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          // parent moves down into the hole
          hw_data   = ha_q;
          pw_addr   = NW'(ha_q.node);
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end
      end
      S_DN_RD: begin
        ha_addr = left[SW-1:0];
        hb_addr = right[SW-1:0];
        if (left >= LW'(cnt_r)) begin
          hw_en     = 1'b1;
          pw_en     = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        hw_en = 1'b1;
        pw_en = 1'b1;
        if (pick.key >= mov_r.key) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          // smaller child (right on a tie) moves up into the hole
          hw_data   = pick;
          pw_addr   = NW'(pick.node);
          pos_nxt   = pick_addr;
          state_nxt = S_DN_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* verif/indexed_min_heap_priority_queue_core_tb.sv */
`timescale 1ns / 1ps
module indexed_min_heap_priority_queue_core_tb;
  import imhpq_pkg::*;

  // operation codes with no function
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    status_t           status;
    logic [NODE_W-1:0] node;
    logic [COST_W-1:0] cost;
    logic [COUNT_W-1:0] count;
  } heap_result_t;

  class heap_scoreboard;
    logic [NODE_W-1:0]  slot_node [CAPACITY_DEF];
    logic [COST_W-1:0]  slot_cost [CAPACITY_DEF];
    int unsigned        pos_of [NODE_IDS_DEF];
    bit                 member [NODE_IDS_DEF];
    int unsigned        n_entries;
    heap_result_t       pending [$];
    int                 mismatches;

    function void clear_all();
      n_entries = 0;
      foreach (member[i]) member[i] = 0;
      pending.delete();
      mismatches = 0;
    endfunction

    function void put(int unsigned p, logic [NODE_W-1:0] nd, logic [COST_W-1:0] c);
      slot_node[p] = nd;
      slot_cost[p] = c;
      pos_of[nd] = p;
    endfunction

    function void bubble_up(int unsigned p);
      logic [NODE_W-1:0] nd;
      logic [COST_W-1:0] c;
      int unsigned par;
      nd = slot_node[p];
      c = slot_cost[p];
      while (p > 0) begin
        par = (p - 1) >> 1;
        if (c >= slot_cost[par]) break;
        put(p, slot_node[par], slot_cost[par]);
        p = par;
      end
      put(p, nd, c);
    endfunction

    function void bubble_down(int unsigned p);
      logic [NODE_W-1:0] nd;
      logic [COST_W-1:0] c;
      int unsigned l, pick;
      nd = slot_node[p];
      c = slot_cost[p];
      forever begin
        l = 2 * p + 1;
        if (l >= n_entries) break;
        pick = l;
        // equal children: right one wins
        if (l + 1 < n_entries && slot_cost[l] >= slot_cost[l + 1]) pick = l + 1;
        if (slot_cost[pick] >= c) break;
        put(p, slot_node[pick], slot_cost[pick]);
        p = pick;
      end
      put(p, nd, c);
    endfunction

    function void note_item(logic [IN_W-1:0] d);
      logic [OP_W-1:0]   op;
      logic [NODE_W-1:0] id;
      logic [COST_W-1:0] c, old;
      int unsigned       p;
      heap_result_t      r;
      op = d[2:0];
      id = d[12:3];
      c = d[44:13];
      r.status = ST_OK;
      r.node = '0;
      r.cost = '0;
      case (op)
        OP_INSERT: begin
          if (member[id]) r.status = ST_PRESENT;
          else if (n_entries >= CAPACITY_DEF) r.status = ST_FULL;
          else begin
            member[id] = 1;
            put(n_entries, id, c);
            n_entries++;
            bubble_up(n_entries - 1);
          end
        end
        OP_POP, OP_PEEK: begin
          if (n_entries == 0) r.status = ST_EMPTY;
          else begin
            r.node = slot_node[0];
            r.cost = slot_cost[0];
            if (op == OP_POP) begin
              n_entries--;
              member[r.node] = 0;
              if (n_entries > 0) begin
                put(0, slot_node[n_entries], slot_cost[n_entries]);
                bubble_down(0);
              end
            end
          end
        end
        OP_REMOVE: begin
          if (!member[id]) r.status = ST_ABSENT;
          else begin
            p = pos_of[id];
            old = slot_cost[p];
            member[id] = 0;
            n_entries--;
            if (p < n_entries) begin
              put(p, slot_node[n_entries], slot_cost[n_entries]);
              if (slot_cost[p] >= old) bubble_down(p);
              else bubble_up(p);
            end
          end
        end
        OP_CHANGE: begin
          if (!member[id]) r.status = ST_ABSENT;
          else begin
            p = pos_of[id];
            old = slot_cost[p];
            slot_cost[p] = c;
            if (c >= old) bubble_down(p);
            else bubble_up(p);
          end
        end
        OP_CLEAR: begin
          n_entries = 0;
          foreach (member[i]) member[i] = 0;
        end
        default: ;
      endcase
      r.count = n_entries[COUNT_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      heap_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", d);
        return;
      end
      e = pending.pop_front();
      if (d[2:0] !== e.status || d[12:3] !== e.node || d[44:13] !== e.cost ||
          d[55:45] !== e.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp st=%0d node=%0d cost=%h cnt=%0d,",
                    " got st=%0d node=%0d cost=%h cnt=%0d"},
                   e.status, e.node, e.cost, e.count,
                   d[2:0], d[12:3], d[44:13], d[55:45]);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [IN_W-1:0] in_tdata;
  logic [OUT_W-1:0] out_tdata;
  int src_idle_pct, sink_stall_pct;
  heap_scoreboard board;

  indexed_min_heap_priority_queue_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: stall pattern changes at falling edges, sample at rising
  always @(negedge clk) out_tready <= ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);

  // called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back items need no gap
  task automatic send_item(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] id,
                           input logic [COST_W-1:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= {3'b0, c, id, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    board.note_item({3'b0, c, id, op});
    @(negedge clk);
  endtask

  // small id pool gives members often; costs often drawn from a few values make ties
  task automatic send_random(input int pool);
    int r;
    logic [COST_W-1:0] c;
    logic [OP_W-1:0] op;
    r = $urandom_range(99);
    if (r < 40) op = OP_INSERT;
    else if (r < 55) op = OP_POP;
    else if (r < 70) op = OP_REMOVE;
    else if (r < 88) op = OP_CHANGE;
    else if (r < 96) op = OP_PEEK;
    else if (r < 98) op = OP_CLEAR;
    else op = ($urandom_range(1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
    c = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom;
    send_item(op, NODE_W'($urandom_range(pool - 1)), c);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  initial begin
    board = new();
    board.clear_all();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed
    send_item(OP_POP, 0, 0);
    send_item(OP_PEEK, 0, 0);
    send_item(OP_REMOVE, 5, 0);
    send_item(OP_CHANGE, 5, 0);
    send_item(OP_INSERT, 10'h3FF, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 0, 32'h0);
    send_item(OP_INSERT, 10'h155, 32'h5555_AAAA);
    send_item(OP_INSERT, 10'h2AA, 32'hAAAA_5555);
    send_item(OP_INSERT, 3, 32'h5555_AAAA);
    send_item(OP_INSERT, 0, 32'h1);
    send_item(OP_PEEK, 0, 0);
    send_item(OP_CHANGE, 0, 32'hFFFF_FFFF);
    send_item(OP_CHANGE, 10'h3FF, 32'h1);
    send_item(OP_REMOVE, 10'h155, 0);
    send_item(OP_SPARE_LO, 1, 1);
    send_item(OP_SPARE_HI, 2, 2);
    send_item(OP_POP, 0, 0);
    send_item(OP_POP, 0, 0);
    send_item(OP_CLEAR, 0, 0);
    send_item(OP_PEEK, 0, 0);
    send_item(OP_INSERT, 10'h3FF, 32'h7);
    send_item(OP_POP, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0; sink_stall_pct = 0; end
        1: begin src_idle_pct = 53; sink_stall_pct = 0; end
        2: begin src_idle_pct = 0; sink_stall_pct = 53; end
        default: begin src_idle_pct = 11; sink_stall_pct = 11; end
      endcase
      for (int i = 0; i < 250; i++) send_random((i < 160) ? 24 : 1024);
    end

    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_item(OP_CLEAR, 0, 0);
    send_item(OP_INSERT, 5, 1);
    send_item(OP_PEEK, 0, 0);
    in_tvalid <= 1'b0;

    drain();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
